// File: src/rfg_pkg.sv
// ----------------------------------------------------------------------------
// RTU frame-gap receiver package
// Shared constants, status and action codes, and the control word that the
// receive controller hands to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package rfg_pkg;

	localparam int BUF_DEPTH  = 128;
	localparam int ADDR_W     = $clog2(BUF_DEPTH);
	localparam int CNT_W      = $clog2(BUF_DEPTH + 1);
	localparam int GAP_W      = 16;
	localparam int STATUS_W   = 3;
	localparam int ACTION_W   = 2;
	localparam int DATA_W     = 8;
	localparam int INDEX_W    = 7;
	localparam int LEN_W      = 8;
	localparam int CFG_IDX_W  = 4;

	localparam logic [GAP_W-1:0] GAP_MAX         = '1;
	localparam logic [GAP_W-1:0] SHORT_GAP_RESET = GAP_W'(11);
	localparam logic [GAP_W-1:0] LONG_GAP_RESET  = GAP_W'(22);

	// Receive status codes.
	localparam logic [STATUS_W-1:0] ST_ARMED     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_RECEIVING = 3'd1;
	localparam logic [STATUS_W-1:0] ST_SHORT_GAP = 3'd2;
	localparam logic [STATUS_W-1:0] ST_COMPLETE  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ERROR     = 3'd4;

	// Input actions.
	localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_BYTE  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_REARM = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_READ  = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_GAP = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_GAP  = 4'd1;

	typedef struct packed {
		logic                wr_en;
		logic [ADDR_W-1:0]   wr_addr;
		logic [STATUS_W-1:0] status;
		logic [LEN_W-1:0]    length;
	} ctrl_t;

endpackage

`default_nettype wire

// File: src/rfg_ctrl.sv
// ----------------------------------------------------------------------------
// RTU frame-gap receive controller
// Holds the gap settings, gap counter, receive status and byte count, applies one
// accepted word per cycle and reports the updated state plus the buffer write it needs.
// ----------------------------------------------------------------------------
`default_nettype none

module rfg_ctrl (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                accept,
	input  wire logic [rfg_pkg::ACTION_W-1:0]        action,
	input  wire logic                                cfg_we,
	input  wire logic [rfg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [rfg_pkg::GAP_W-1:0]           cfg_data,
	output rfg_pkg::ctrl_t                           ctrl
);

	logic [rfg_pkg::GAP_W-1:0]    short_gap_q;
	logic [rfg_pkg::GAP_W-1:0]    long_gap_q;
	logic [rfg_pkg::GAP_W-1:0]    gap_q;
	logic [rfg_pkg::GAP_W-1:0]    gap_n;
	logic [rfg_pkg::STATUS_W-1:0] status_q;
	logic [rfg_pkg::STATUS_W-1:0] status_n;
	logic [rfg_pkg::CNT_W-1:0]    count_q;
	logic [rfg_pkg::CNT_W-1:0]    count_n;
	logic [rfg_pkg::CNT_W-1:0]    base;
	logic                         wr_en;
	logic [rfg_pkg::ADDR_W-1:0]   wr_addr;

	always_comb begin
		gap_n    = gap_q;
		status_n = status_q;
		count_n  = count_q;
		base     = count_q;
		wr_en    = 1'b0;
		wr_addr  = '0;
		if (accept) begin
			unique case (action)
				rfg_pkg::ACT_TICK: begin
					if (gap_q != rfg_pkg::GAP_MAX)
						gap_n = gap_q + 1'b1;
					// Both gap checks run in the same tick, short first.
					if (gap_n > short_gap_q && status_n == rfg_pkg::ST_RECEIVING)
						status_n = rfg_pkg::ST_SHORT_GAP;
					if (gap_n > long_gap_q && status_n == rfg_pkg::ST_SHORT_GAP)
						status_n = rfg_pkg::ST_COMPLETE;
				end
				rfg_pkg::ACT_BYTE: begin
					gap_n = '0;
					if (status_q == rfg_pkg::ST_ARMED) begin
						base     = '0;
						status_n = rfg_pkg::ST_RECEIVING;
					end
					if (status_n == rfg_pkg::ST_RECEIVING) begin
						// A full buffer wraps to the first position.
						if (base >= rfg_pkg::CNT_W'(rfg_pkg::BUF_DEPTH))
							base = '0;
						wr_en   = 1'b1;
						wr_addr = base[rfg_pkg::ADDR_W-1:0];
						count_n = base + 1'b1;
					end else if (status_n == rfg_pkg::ST_SHORT_GAP) begin
						status_n = rfg_pkg::ST_ERROR;
					end
				end
				rfg_pkg::ACT_REARM: begin
					status_n = rfg_pkg::ST_ARMED;
				end
				rfg_pkg::ACT_READ: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_gap_q <= rfg_pkg::SHORT_GAP_RESET;
			long_gap_q  <= rfg_pkg::LONG_GAP_RESET;
			gap_q       <= '0;
			status_q    <= rfg_pkg::ST_ARMED;
			count_q     <= '0;
		end else begin
			if (cfg_we && cfg_index == rfg_pkg::CFG_SHORT_GAP)
				short_gap_q <= cfg_data;
			if (cfg_we && cfg_index == rfg_pkg::CFG_LONG_GAP)
				long_gap_q <= cfg_data;
			gap_q    <= gap_n;
			status_q <= status_n;
			count_q  <= count_n;
		end
	end

	assign ctrl.wr_en   = wr_en;
	assign ctrl.wr_addr = wr_addr;
	assign ctrl.status  = status_n;
	assign ctrl.length  = rfg_pkg::LEN_W'(count_n);

endmodule

`default_nettype wire

// File: src/rtu_frame_gap_receiver.sv
// ----------------------------------------------------------------------------
// RTU frame-gap receiver
// Delimits received frames by line silence and stores frame bytes in an
// on-chip buffer that can be read back one byte per word.
// ----------------------------------------------------------------------------
// An accepted input word loads stage one (state update and buffer read) at its
// accepting edge; its result moves on to the output register when that is free.
// Throughput: one word per cycle unless stalled; buffer has one write, one read port.
// Reset clears status, gap counter and byte count and restores the gap defaults
// at once; the frame buffer is not cleared and needs no reset pass.
`default_nettype none

module rtu_frame_gap_receiver (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output      logic                              in_ready,
	input  wire logic [rfg_pkg::ACTION_W-1:0]      action,
	input  wire logic [rfg_pkg::DATA_W-1:0]        rx_byte,
	input  wire logic [rfg_pkg::INDEX_W-1:0]       read_index,
	output      logic                              out_valid,
	input  wire logic                              out_ready,
	output      logic [rfg_pkg::STATUS_W-1:0]      rx_status,
	output      logic [rfg_pkg::LEN_W-1:0]         frame_length,
	output      logic [rfg_pkg::DATA_W-1:0]        read_data,
	input  wire logic                              cfg_valid,
	output      logic                              cfg_ready,
	input  wire logic [rfg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [rfg_pkg::GAP_W-1:0]         cfg_data
);

	rfg_pkg::ctrl_t               ctrl;
	logic                         accept;
	logic                         rd_en;
	logic                         rd_in_range;
	logic                         go_s1;
	logic                         valid_s1;
	logic                         is_read_s1;
	logic [rfg_pkg::STATUS_W-1:0] status_s1;
	logic [rfg_pkg::LEN_W-1:0]    length_s1;
	logic [rfg_pkg::DATA_W-1:0]   mem_rd_s1;
	logic                         out_valid_q;
	logic [rfg_pkg::STATUS_W-1:0] status_q;
	logic [rfg_pkg::LEN_W-1:0]    length_q;
	logic [rfg_pkg::DATA_W-1:0]   data_q;

	logic [rfg_pkg::DATA_W-1:0]   frame_mem [rfg_pkg::BUF_DEPTH];

	assign cfg_ready   = 1'b1;
	assign go_s1       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready    = !valid_s1 || go_s1;
	assign accept      = in_valid && in_ready;
	assign rd_in_range = 32'(read_index) < rfg_pkg::BUF_DEPTH;
	assign rd_en       = accept && action == rfg_pkg::ACT_READ && rd_in_range;

	rfg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.action    (action),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctrl      (ctrl)
	);

	// Frame buffer: one write and one registered read per cycle. A read word
	// always comes after any write word that filled its entry, so no bypass is needed.
	always_ff @(posedge clk) begin
		if (ctrl.wr_en)
			frame_mem[ctrl.wr_addr] <= rx_byte;
		if (rd_en)
			mem_rd_s1 <= frame_mem[rfg_pkg::ADDR_W'(read_index)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (go_s1)
				valid_s1 <= 1'b0;
			if (go_s1)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_read_s1 <= rd_en;
			status_s1  <= ctrl.status;
			length_s1  <= ctrl.length;
		end
		if (go_s1) begin
			status_q <= status_s1;
			length_q <= length_s1;
			data_q   <= is_read_s1 ? mem_rd_s1 : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign rx_status    = status_q;
	assign frame_length = length_q;
	assign read_data    = data_q;

	// A buffer write only happens while a frame is being received.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.wr_en |-> (accept && ctrl.status == rfg_pkg::ST_RECEIVING))
		else $error("buffer write outside of receiving state");

	// The reported length never exceeds the buffer depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (32'(length_s1) <= rfg_pkg::BUF_DEPTH))
		else $error("frame length beyond buffer depth");

	// A stalled stage-one word keeps its status and, for a read, its buffer data.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !go_s1) |=> $stable(status_s1) && (!is_read_s1 || $stable(mem_rd_s1)))
		else $error("stage one word changed while stalled");

	// Stage one never moves while a result is waiting and not taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !go_s1)
		else $error("output word overwritten");

endmodule

`default_nettype wire
